// File: src/tkbs_pkg.sv
// Shared types and fixed field widths for the top-k byte selector.
package tkbs_pkg;

	localparam int VAL_W  = 8;
	localparam int IDX_W  = 10;
	localparam int RANK_W = 4;
	localparam int K_W    = 4;

	localparam logic [K_W-1:0] K_RESET = 4'd15;
	localparam int RESULT_CAP = 15;

	typedef struct packed {
		logic ins;
		logic shift;
		logic clr;
	} cell_cmd_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

endpackage

// File: src/tkbs_cell.sv
// One entry of the sorted list: compares the broadcast pair and shifts with its neighbors.
module tkbs_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tkbs_pkg::cell_cmd_t       cmd,
	input  logic [tkbs_pkg::VAL_W-1:0] new_val,
	input  logic [tkbs_pkg::IDX_W-1:0] new_idx,
	input  logic                      prev_valid,
	input  logic                      prev_gt,
	input  logic [tkbs_pkg::VAL_W-1:0] prev_val,
	input  logic [tkbs_pkg::IDX_W-1:0] prev_idx,
	input  logic                      next_valid,
	input  logic [tkbs_pkg::VAL_W-1:0] next_val,
	input  logic [tkbs_pkg::IDX_W-1:0] next_idx,
	output logic                      valid,
	output logic [tkbs_pkg::VAL_W-1:0] val,
	output logic [tkbs_pkg::IDX_W-1:0] idx,
	output logic                      gt
);
	import tkbs_pkg::*;

	logic               valid_q;
	logic [VAL_W-1:0]   val_q;
	logic [IDX_W-1:0]   idx_q;
	logic               above;

	// new pair ranks strictly above the stored one; lower index wins a tie
	assign above = (new_val > val_q) || ((new_val == val_q) && (new_idx < idx_q));
	assign gt    = !valid_q || above;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= next_valid;
		end else if (cmd.ins && gt) begin
			// an entry moved down from the upper neighbor keeps that neighbor's valid bit
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			val_q <= next_val;
			idx_q <= next_idx;
		end else if (cmd.ins && gt) begin
			// take the upper neighbor's entry if the new pair lands above it
			if (prev_gt) begin
				val_q <= prev_val;
				idx_q <= prev_idx;
			end else begin
				val_q <= new_val;
				idx_q <= new_idx;
			end
		end
	end

	assign valid = valid_q;
	assign val   = val_q;
	assign idx   = idx_q;

endmodule

// File: src/tkbs_ctrl.sv
// Window position, group-reversed index, k_count register and drain sequencer.
module tkbs_ctrl #(
	parameter int ITEM_COUNT = 1024,
	parameter int MAX_TOP    = 15,
	parameter int GROUP_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        last_item,
	input  logic                        cfg_we,
	input  logic [tkbs_pkg::K_W-1:0]    cfg_wdata,
	input  logic                        second_valid,
	output tkbs_pkg::cell_cmd_t         cmd,
	output logic [tkbs_pkg::IDX_W-1:0]  new_idx,
	output logic                        busy,
	output logic                        result_valid,
	output logic [tkbs_pkg::RANK_W-1:0] rank,
	output logic                        last_result
);
	import tkbs_pkg::*;

	localparam int PW = $clog2(ITEM_COUNT);
	localparam int OW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int SW = ((PW > IDX_W) ? PW : IDX_W) + 1;
	localparam logic [K_W-1:0] TOP_LIM =
		K_W'((MAX_TOP < RESULT_CAP) ? MAX_TOP : RESULT_CAP);

	state_t            state_q, state_d;
	logic [PW-1:0]     pos_q;
	logic [OW-1:0]     off_q;
	logic [SW-1:0]     base_q;
	logic [K_W-1:0]    k_count_q;
	logic [K_W-1:0]    k_eff;
	logic [RANK_W-1:0] rank_q;
	logic              accept;
	logic              wrap;
	logic [SW-1:0]     rev_sum;

	assign accept = start && (state_q == ST_FILL);
	assign wrap   = (pos_q == PW'(ITEM_COUNT - 1));

	assign rev_sum = base_q + SW'(GROUP_SIZE - 1) - SW'(off_q);
	assign new_idx = rev_sum[IDX_W-1:0];

	always_comb begin
		k_eff = (k_count_q == '0) ? K_W'(1) : k_count_q;
		if (k_eff > TOP_LIM) begin
			k_eff = TOP_LIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_count_q <= K_RESET;
		end else if (cfg_we) begin
			k_count_q <= cfg_wdata;
		end
	end

	// position in window, kept as group base plus offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			off_q  <= '0;
			base_q <= '0;
		end else if (accept) begin
			if (last_item || wrap) begin
				pos_q  <= '0;
				off_q  <= '0;
				base_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
				if (off_q == OW'(GROUP_SIZE - 1)) begin
					off_q  <= '0;
					base_q <= base_q + SW'(GROUP_SIZE);
				end else begin
					off_q <= off_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			rank_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAIN && !last_result) begin
				rank_q <= rank_q + RANK_W'(1);
			end else begin
				rank_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (accept && last_item) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_result) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		busy         = 1'b0;
		result_valid = 1'b0;
		last_result  = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_FILL: begin
				cmd.ins = accept;
			end
			ST_DRAIN: begin
				busy         = 1'b1;
				result_valid = 1'b1;
				last_result  = (rank_q == RANK_W'(k_eff - K_W'(1))) || !second_valid;
				// advance the list toward the head; empty it after the final rank
				cmd.shift    = 1'b1;
				cmd.clr      = last_result;
			end
			default: ;
		endcase
	end

	assign rank = rank_q;

	a_result_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside drain");

	a_last_enters_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> (result_valid && rank == '0))
		else $error("drain did not start at rank zero after last byte");

	a_rank_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_result) |=> (result_valid && rank == $past(rank) + RANK_W'(1)))
		else $error("rank did not advance during drain");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_result |=> !busy)
		else $error("block still busy after final rank");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (rank < k_eff))
		else $error("rank beyond requested count");

endmodule

// File: src/top_k_byte_select_with_index.sv
// Top level: row of sorted-list cells driven by the window controller.
// Latency: a byte is inserted into the list at the edge that accepts it; after the last byte
// the first result shows in the next cycle, then one result per cycle for n = min(fill, k)
// results, a k of zero counting as one. Throughput: one byte per cycle while filling; busy is
// high through each drain, which runs on the single shift path of the cell row toward its head.
// Reset: list empty, position zero, k_count 15; results cannot be stalled by the receiver.
module top_k_byte_select_with_index #(
	parameter int ITEM_COUNT = 1024,
	parameter int MAX_TOP    = 15,
	parameter int GROUP_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tkbs_pkg::VAL_W-1:0]  value,
	input  logic                        last_item,
	input  logic                        cfg_we,
	input  logic [tkbs_pkg::K_W-1:0]    cfg_wdata,
	output logic                        result_valid,
	output logic [tkbs_pkg::RANK_W-1:0] rank,
	output logic [tkbs_pkg::IDX_W-1:0]  item_index,
	output logic [tkbs_pkg::VAL_W-1:0]  item_value,
	output logic                        last_result
);
	import tkbs_pkg::*;

	cell_cmd_t        cmd;
	logic [IDX_W-1:0] new_idx;
	logic             c_valid [MAX_TOP];
	logic [VAL_W-1:0] c_val   [MAX_TOP];
	logic [IDX_W-1:0] c_idx   [MAX_TOP];
	logic             c_gt    [MAX_TOP];
	logic             second_valid;

	tkbs_ctrl #(
		.ITEM_COUNT (ITEM_COUNT),
		.MAX_TOP    (MAX_TOP),
		.GROUP_SIZE (GROUP_SIZE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_item    (last_item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.second_valid (second_valid),
		.cmd          (cmd),
		.new_idx      (new_idx),
		.busy         (busy),
		.result_valid (result_valid),
		.rank         (rank),
		.last_result  (last_result)
	);

	for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
		logic             p_valid;
		logic             p_gt;
		logic [VAL_W-1:0] p_val;
		logic [IDX_W-1:0] p_idx;
		logic             n_valid;
		logic [VAL_W-1:0] n_val;
		logic [IDX_W-1:0] n_idx;

		if (i == 0) begin : g_head
			assign p_valid = 1'b0;
			assign p_gt    = 1'b0;
			assign p_val   = '0;
			assign p_idx   = '0;
		end else begin : g_mid
			assign p_valid = c_valid[i-1];
			assign p_gt    = c_gt[i-1];
			assign p_val   = c_val[i-1];
			assign p_idx   = c_idx[i-1];
		end

		if (i == MAX_TOP - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_val   = '0;
			assign n_idx   = '0;
		end else begin : g_body
			assign n_valid = c_valid[i+1];
			assign n_val   = c_val[i+1];
			assign n_idx   = c_idx[i+1];
		end

		tkbs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_val    (value),
			.new_idx    (new_idx),
			.prev_valid (p_valid),
			.prev_gt    (p_gt),
			.prev_val   (p_val),
			.prev_idx   (p_idx),
			.next_valid (n_valid),
			.next_val   (n_val),
			.next_idx   (n_idx),
			.valid      (c_valid[i]),
			.val        (c_val[i]),
			.idx        (c_idx[i]),
			.gt         (c_gt[i])
		);
	end

	assign second_valid = g_cell[0].n_valid;

	// head of the row is the current rank during drain
	assign item_value = c_val[0];
	assign item_index = c_idx[0];

endmodule

// File: tb/sv/tkbs_checker.sv
`timescale 1ns / 100ps
// Checker for the top-k byte selector: tracks the ranked list, predicts results and compares them.
module tkbs_checker
	import tkbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [VAL_W-1:0]  value,
	input  logic              last_item,
	input  logic              cfg_we,
	input  logic [K_W-1:0]    cfg_wdata,
	input  logic              result_valid,
	input  logic [RANK_W-1:0] rank,
	input  logic [IDX_W-1:0]  item_index,
	input  logic [VAL_W-1:0]  item_value,
	input  logic              last_result,
	output int                fail_count,
	output int                pending,
	output int                windows_seen,
	output int                results_seen
);

	localparam int LIST_DEPTH = 15;
	// index reversal inside a 16-byte group
	localparam logic [IDX_W-1:0] GROUP_FLIP = 10'd15;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
		logic              fin;
	} ranked_byte_t;

	logic [VAL_W-1:0] top_values [LIST_DEPTH];
	logic [IDX_W-1:0] top_indices [LIST_DEPTH];
	int               top_fill;
	logic [IDX_W-1:0] window_pos;
	logic [K_W-1:0]   k_setting;
	ranked_byte_t     ranked_queue [$];

	// higher value wins; on equal values the lower index wins
	function automatic bit outranks(input logic [VAL_W-1:0] va, input logic [IDX_W-1:0] ia,
			input logic [VAL_W-1:0] vb, input logic [IDX_W-1:0] ib);
		if (va != vb)
			return va > vb;
		return ia < ib;
	endfunction

	task automatic clear_list();
		for (int i = 0; i < LIST_DEPTH; i++) begin
			top_values[i] = '0;
			top_indices[i] = '0;
		end
		top_fill = 0;
		window_pos = '0;
	endtask

	task automatic insert_byte(input logic [VAL_W-1:0] v, input logic [IDX_W-1:0] idx);
		int slot;
		int j;
		slot = 0;
		while (slot < top_fill && !outranks(v, idx, top_values[slot], top_indices[slot]))
			slot++;
		if (slot < LIST_DEPTH) begin
			// shift the tail down, dropping the bottom entry when the list is full
			j = (top_fill < LIST_DEPTH) ? top_fill : LIST_DEPTH - 1;
			while (j > slot) begin
				top_values[j] = top_values[j-1];
				top_indices[j] = top_indices[j-1];
				j--;
			end
			top_values[slot] = v;
			top_indices[slot] = idx;
			if (top_fill < LIST_DEPTH)
				top_fill++;
		end
	endtask

	task automatic close_window();
		int k;
		int n;
		ranked_byte_t r;
		k = (k_setting == '0) ? 1 : int'(k_setting);
		if (k > LIST_DEPTH)
			k = LIST_DEPTH;
		n = (top_fill < k) ? top_fill : k;
		for (int i = 0; i < n; i++) begin
			r.rank = RANK_W'(i);
			r.index = top_indices[i];
			r.value = top_values[i];
			r.fin = (i == n - 1);
			ranked_queue = {ranked_queue, r};
		end
		clear_list();
	endtask

	task automatic check_result();
		ranked_byte_t want;
		if (ranked_queue.size() == 0) begin
			$error("unexpected result: rank %0d index %0d value %0d", rank, item_index, item_value);
			fail_count++;
			return;
		end
		want = ranked_queue.pop_front();
		if (rank !== want.rank) begin
			$error("rank: expected %0d, got %0d", want.rank, rank);
			fail_count++;
		end
		if (item_index !== want.index) begin
			$error("item_index: expected %0d, got %0d", want.index, item_index);
			fail_count++;
		end
		if (item_value !== want.value) begin
			$error("item_value: expected %0d, got %0d", want.value, item_value);
			fail_count++;
		end
		if (last_result !== want.fin) begin
			$error("last_result: expected %0d, got %0d", want.fin, last_result);
			fail_count++;
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_list();
			k_setting = K_RESET;
			ranked_queue.delete();
			fail_count = 0;
			pending = 0;
			windows_seen = 0;
			results_seen = 0;
		end else begin
			if (result_valid)
				check_result();
			if (cfg_we)
				k_setting = cfg_wdata;
			if (start && !busy) begin
				insert_byte(value, window_pos ^ GROUP_FLIP);
				window_pos = window_pos + 1'b1;
				if (last_item) begin
					close_window();
					windows_seen++;
				end
			end
			pending = ranked_queue.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the top-k byte selector: clock, reset, stimulus, watchdog and verdict.
module tb;
	import tkbs_pkg::*;

	typedef enum int {
		MIX_UNIFORM,
		MIX_TIED,
		MIX_HIGH,
		MIX_RAMP,
		MIX_FALL
	} value_mix_t;

	localparam int RANDOM_BYTES = 330;
	localparam int QUIET_LIMIT  = 500;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [VAL_W-1:0]  value;
	logic              last_item;
	logic              cfg_we;
	logic [K_W-1:0]    cfg_wdata;
	logic              result_valid;
	logic [RANK_W-1:0] rank;
	logic [IDX_W-1:0]  item_index;
	logic [VAL_W-1:0]  item_value;
	logic              last_result;

	int fail_count;
	int pending;
	int windows_seen;
	int results_seen;
	int burst_left = 0;
	int max_gap = 0;
	int k_writes = 0;
	int quiet_cycles = 0;

	top_k_byte_select_with_index uut (.*);

	tkbs_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// end the run if no transaction, result or register write happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("top_k_byte_select_with_index test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [VAL_W-1:0] pick_value(input value_mix_t mix, input int pos);
		case (mix)
			MIX_TIED: return VAL_W'(85 * $urandom_range(0, 3));
			MIX_HIGH: return VAL_W'($urandom_range(248, 255));
			MIX_RAMP: return VAL_W'(pos);
			MIX_FALL: return VAL_W'(255 - pos);
			default:  return VAL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_byte(input logic [VAL_W-1:0] v, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if ($urandom_range(0, 15) == 0)
				gap = gap * 4;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		start <= 1'b1;
		value <= v;
		last_item <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_window(input int len, input value_mix_t mix);
		for (int i = 0; i < len; i++)
			send_byte(pick_value(mix, i), i == len - 1);
	endtask

	// drop start, wait out the drain, then idle before returning
	task automatic settle();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_k(input logic [K_W-1:0] k);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_we <= 1'b0;
		k_writes++;
	endtask

	initial begin
		int random_sent;
		int phase;
		int len;
		logic [K_W-1:0] k;
		value_mix_t mix;

		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last_item = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short window under the reset k, with extremes and tied values
		send_byte(8'd255, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(8'd128, 1'b0);
		send_byte(8'd128, 1'b0);
		send_byte(8'd1, 1'b0);
		send_byte(8'd254, 1'b0);
		send_byte(8'd0, 1'b1);
		// k of zero reports one entry
		write_k(4'd0);
		send_byte(8'd7, 1'b0);
		send_byte(8'd200, 1'b0);
		send_byte(8'd200, 1'b1);
		// single-byte window
		write_k(4'd1);
		send_byte(8'd255, 1'b1);
		// all values equal: order comes from the index alone
		write_k(4'd5);
		for (int i = 0; i < 8; i++)
			send_byte(8'h5A, i == 7);

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_BYTES) begin
			case (phase)
				0:       k = 4'd15;
				1:       k = 4'd1;
				2:       k = 4'd0;
				default: k = K_W'($urandom_range(0, 15));
			endcase
			write_k(k);
			max_gap = (phase % 3 == 0) ? 0 : $urandom_range(1, 10);
			repeat ($urandom_range(2, 5)) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 16);
				mix = value_mix_t'($urandom_range(0, 4));
				send_window(len, mix);
				random_sent += len;
			end
			phase++;
		end

		settle();
		repeat (20) @(negedge clk);

		$display("Checked %0d windows and %0d ranked results across %0d k_count writes,",
			windows_seen, results_seen, k_writes);
		$display("including ties, short and full windows, k of zero and bursts with idle gaps.");
		if (fail_count == 0 && pending == 0)
			$display("top_k_byte_select_with_index test passed");
		else
			$display("top_k_byte_select_with_index test failed");
		$finish;
	end

endmodule

// File: top_k_byte_select_with_index.f
src/tkbs_pkg.sv
src/tkbs_cell.sv
src/tkbs_ctrl.sv
src/top_k_byte_select_with_index.sv
tb/sv/tkbs_checker.sv
tb/sv/tb.sv
